// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the serial time clock checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define STCC_ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define STCC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/stcc_pkg.sv =====
// ----------------------------------------------------------------------------
// stcc_pkg
// Types, character codes and helpers for the serial time command clock.
// ----------------------------------------------------------------------------
package stcc_pkg;

  localparam int LINE_CHARS_DEF = 15;
  localparam int TIME_W         = 7;
  localparam int RESET_LEN      = 12;
  localparam int TIME_LEN       = 8;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  localparam logic [TIME_W-1:0] SEC_WRAP   = 7'd60;
  localparam logic [TIME_W-1:0] MIN_WRAP   = 7'd60;
  localparam logic [TIME_W-1:0] HOUR_WRAP  = 7'd24;
  localparam logic [TIME_W-1:0] FIELD_WRAP = 7'd100;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_RESET = 2'd1,
    EV_LOAD  = 2'd2,
    EV_TICK  = 2'd3
  } event_t;

  typedef struct packed {
    logic [TIME_W-1:0] hours;
    logic [TIME_W-1:0] minutes;
    logic [TIME_W-1:0] seconds;
    event_t            event_res;
  } result_t;

  // characters of the clear-time command line by position
  function automatic logic [7:0] reset_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h52; // R
      4'd1:    c = 8'h45; // E
      4'd2:    c = 8'h53; // S
      4'd3:    c = 8'h45; // E
      4'd4:    c = 8'h54; // T
      4'd5:    c = 8'h5F; // _
      4'd6:    c = 8'h53; // S
      4'd7:    c = 8'h59; // Y
      4'd8:    c = 8'h53; // S
      4'd9:    c = 8'h54; // T
      4'd10:   c = 8'h45; // E
      4'd11:   c = 8'h4D; // M
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // tens*10 + ones, both decimal digits
  function automatic logic [TIME_W-1:0] two_digits(input logic [3:0] tens,
                                                   input logic [3:0] ones);
    logic [TIME_W-1:0] t;
    t = TIME_W'({tens, 3'b000}) + TIME_W'({tens, 1'b0});
    return t + TIME_W'(ones);
  endfunction

endpackage

// ===== hw/rtl/serial_time_command_clock_core.sv =====
// ----------------------------------------------------------------------------
// serial_time_command_clock_core
// Serial command line parser and seconds clock with HH:MM:SS load and reset.
// ----------------------------------------------------------------------------
// Each input transfer's result is registered in the output register, or in the
//   skid entry while the output is stalled. A two-entry output buffer keeps
//   in_stall registered. Throughput: one item per cycle while in_stall is low;
//   the line is checked as it arrives, so the newline is handled like any byte.
// Reset: synchronous, clears time, fresh mark, line length and the output buffer.
module serial_time_command_clock_core #(
  parameter int LINE_CHARS = stcc_pkg::LINE_CHARS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [stcc_pkg::TIME_W-1:0] out_hours,
  output logic [stcc_pkg::TIME_W-1:0] out_minutes,
  output logic [stcc_pkg::TIME_W-1:0] out_seconds,
  output logic [1:0]                  out_event_res
);

  localparam int LW = $clog2(LINE_CHARS + 1);
  localparam int TW = stcc_pkg::TIME_W;

  logic [LW-1:0]    line_len_r, line_len_nxt;
  logic             rst_ok_r, rst_ok_nxt;
  logic             time_ok_r, time_ok_nxt;
  logic [3:0]       dig_r [6];
  logic [3:0]       dig_nxt [6];
  logic [TW-1:0]    hour_r, hour_nxt;
  logic [TW-1:0]    min_r, min_nxt;
  logic [TW-1:0]    sec_r, sec_nxt;
  logic             fresh_r, fresh_nxt;

  stcc_pkg::result_t out_r, out_nxt;
  stcc_pkg::result_t skid_r, skid_nxt;
  stcc_pkg::result_t res;
  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;

  logic          accept;
  logic          out_free;
  logic          is_nl;
  logic          is_dig;
  logic          at_start;
  logic          room;
  logic          rst_char_ok;
  logic          colon_pos;
  logic          time_char_ok;
  logic [TW-1:0] s1, m1, h1;
  logic          carry_m, carry_h;
  logic [TW-1:0] s_adv, m_adv, h_adv;

  assign accept   = in_valid && !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  assign is_nl    = in_rx_byte == stcc_pkg::CH_NEWLINE;
  assign is_dig   = in_rx_byte >= stcc_pkg::CH_ZERO && in_rx_byte <= stcc_pkg::CH_NINE;
  assign at_start = line_len_r == '0;
  assign room     = line_len_r < LW'(LINE_CHARS);

  assign rst_char_ok  = (line_len_r < LW'(stcc_pkg::RESET_LEN)) &&
                        (in_rx_byte == stcc_pkg::reset_char(line_len_r[3:0]));
  assign colon_pos    = line_len_r == LW'(2) || line_len_r == LW'(5);
  assign time_char_ok = colon_pos ? (in_rx_byte == stcc_pkg::CH_COLON) : is_dig;

  // clock advance
  assign s1      = sec_r + TW'(1);
  assign carry_m = s1 == stcc_pkg::SEC_WRAP;
  assign s_adv   = (carry_m || s1 >= stcc_pkg::FIELD_WRAP) ? '0 : s1;
  assign m1      = min_r + TW'(carry_m);
  assign carry_h = m1 == stcc_pkg::MIN_WRAP;
  assign m_adv   = (carry_h || m1 >= stcc_pkg::FIELD_WRAP) ? '0 : m1;
  assign h1      = hour_r + TW'(carry_h);
  assign h_adv   = (h1 == stcc_pkg::HOUR_WRAP || h1 >= stcc_pkg::FIELD_WRAP) ? '0 : h1;

  always_comb begin
    line_len_nxt  = line_len_r;
    rst_ok_nxt    = rst_ok_r;
    time_ok_nxt   = time_ok_r;
    dig_nxt       = dig_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    sec_nxt       = sec_r;
    fresh_nxt     = fresh_r;
    res.event_res = stcc_pkg::EV_NONE;
    res.hours     = hour_r;
    res.minutes   = min_r;
    res.seconds   = sec_r;

    if (accept) begin
      if (in_action) begin
        res.event_res = stcc_pkg::EV_TICK;
        if (fresh_r) begin
          fresh_nxt = 1'b0;
        end else begin
          hour_nxt = h_adv;
          min_nxt  = m_adv;
          sec_nxt  = s_adv;
        end
      end else if (is_nl) begin
        line_len_nxt = '0;
        if (line_len_r == LW'(stcc_pkg::RESET_LEN) && rst_ok_r) begin
          hour_nxt      = '0;
          min_nxt       = '0;
          sec_nxt       = '0;
          fresh_nxt     = 1'b0;
          res.event_res = stcc_pkg::EV_RESET;
        end else if (line_len_r == LW'(stcc_pkg::TIME_LEN) && time_ok_r) begin
          hour_nxt      = stcc_pkg::two_digits(dig_r[0], dig_r[1]);
          min_nxt       = stcc_pkg::two_digits(dig_r[2], dig_r[3]);
          sec_nxt       = stcc_pkg::two_digits(dig_r[4], dig_r[5]);
          fresh_nxt     = 1'b1;
          res.event_res = stcc_pkg::EV_LOAD;
        end
        res.hours   = hour_nxt;
        res.minutes = min_nxt;
        res.seconds = sec_nxt;
      end else if (room) begin
        line_len_nxt = line_len_r + LW'(1);
        rst_ok_nxt   = (at_start || rst_ok_r) && rst_char_ok;
        time_ok_nxt  = (at_start || time_ok_r) && time_char_ok;
        if (line_len_r < LW'(stcc_pkg::TIME_LEN)) begin
          case (line_len_r[2:0])
            3'd0:    dig_nxt[0] = in_rx_byte[3:0];
            3'd1:    dig_nxt[1] = in_rx_byte[3:0];
            3'd3:    dig_nxt[2] = in_rx_byte[3:0];
            3'd4:    dig_nxt[3] = in_rx_byte[3:0];
            3'd6:    dig_nxt[4] = in_rx_byte[3:0];
            3'd7:    dig_nxt[5] = in_rx_byte[3:0];
            default: ;
          endcase
        end
      end
    end
  end

  // output register with one skid entry
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_free) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      if (out_free) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r   <= '0;
      rst_ok_r     <= 1'b0;
      time_ok_r    <= 1'b0;
      hour_r       <= '0;
      min_r        <= '0;
      sec_r        <= '0;
      fresh_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      line_len_r   <= line_len_nxt;
      rst_ok_r     <= rst_ok_nxt;
      time_ok_r    <= time_ok_nxt;
      hour_r       <= hour_nxt;
      min_r        <= min_nxt;
      sec_r        <= sec_nxt;
      fresh_r      <= fresh_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r  <= dig_nxt;
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_hours     = out_r.hours;
  assign out_minutes   = out_r.minutes;
  assign out_seconds   = out_r.seconds;
  assign out_event_res = out_r.event_res;

endmodule

// ===== hw/rtl/stcc_checker.sv =====
// ----------------------------------------------------------------------------
// stcc_checker
// Port-level checks for the serial time command clock, bound to serial_time_command_clock_core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stcc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        in_action,
  input logic [7:0]                  in_rx_byte,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [stcc_pkg::TIME_W-1:0] out_hours,
  input logic [stcc_pkg::TIME_W-1:0] out_minutes,
  input logic [stcc_pkg::TIME_W-1:0] out_seconds,
  input logic [1:0]                  out_event_res
);

  `STCC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !in_stall, "buffer not empty after reset")

  `STCC_ASSERT_ON(a_stall_needs_full, in_stall |-> out_valid, "input stalled with no result waiting")

  `STCC_ASSERT_ON(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_hours) && $stable(out_minutes) && $stable(out_seconds) && $stable(out_event_res), "stalled result changed")

  `STCC_ASSERT_ON(a_time_range, out_valid |-> out_hours < 7'd100 && out_minutes < 7'd100 && out_seconds < 7'd100, "time field out of range")

  `STCC_ASSERT_ON(a_reset_cmd_zero, out_valid && out_event_res == stcc_pkg::EV_RESET |-> out_hours == '0 && out_minutes == '0 && out_seconds == '0, "reset command left time nonzero")

endmodule

bind serial_time_command_clock_core stcc_checker u_stcc_checker (.*);

// ===== tb/sv/stcc_clock_checker.sv =====
// ----------------------------------------------------------------------------
// stcc_clock_checker
// Watches both channels of the serial time command clock. It keeps its own
// copy of the line store, the time and the fresh mark, works out the
// result of every input transfer and compares each result transfer, field by
// field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module stcc_clock_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_action,
  input  logic [7:0]                  in_rx_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [stcc_pkg::TIME_W-1:0] out_hours,
  input  logic [stcc_pkg::TIME_W-1:0] out_minutes,
  input  logic [stcc_pkg::TIME_W-1:0] out_seconds,
  input  logic [1:0]                  out_event_res,
  output int                          fail_count,
  output int                          pending,
  output int                          checked
);
  import stcc_pkg::*;

  logic [7:0]  line_buf [LINE_CHARS_DEF];
  int unsigned line_len;
  int unsigned hr, mn, sc;
  bit          fresh;
  result_t     expected_times [$];
  int          mismatches = 0;
  int          results_seen = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    foreach (line_buf[i]) line_buf[i] = 8'h00;
  end

  function automatic bit is_dec(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic predict_clock_step(input logic act, input logic [7:0] ch);
    result_t     r;
    bit          match;
    int unsigned s, m, h;
    r.hours     = TIME_W'(hr);
    r.minutes   = TIME_W'(mn);
    r.seconds   = TIME_W'(sc);
    r.event_res = EV_NONE;
    if (act) begin
      r.event_res = EV_TICK;
      if (fresh) begin
        fresh = 1'b0;
      end else begin
        s = sc + 1;
        m = mn;
        h = hr;
        if (s == SEC_WRAP) begin
          s = 0;
          m++;
        end else if (s >= FIELD_WRAP) begin
          s = 0;
        end
        if (m == MIN_WRAP) begin
          m = 0;
          h++;
        end else if (m >= FIELD_WRAP) begin
          m = 0;
        end
        if (h == HOUR_WRAP || h >= FIELD_WRAP) h = 0;
        sc = s;
        mn = m;
        hr = h;
      end
    end else if (ch == CH_NEWLINE) begin
      match = (line_len == RESET_LEN);
      for (int i = 0; i < RESET_LEN; i++) begin
        if (match && line_buf[i] != reset_char(4'(i))) match = 1'b0;
      end
      if (match) begin
        hr = 0;
        mn = 0;
        sc = 0;
        fresh = 1'b0;
        r.event_res = EV_RESET;
      end else if (line_len == TIME_LEN && line_buf[2] == CH_COLON &&
                   line_buf[5] == CH_COLON &&
                   is_dec(line_buf[0]) && is_dec(line_buf[1]) &&
                   is_dec(line_buf[3]) && is_dec(line_buf[4]) &&
                   is_dec(line_buf[6]) && is_dec(line_buf[7])) begin
        hr = (line_buf[0] - CH_ZERO) * 10 + (line_buf[1] - CH_ZERO);
        mn = (line_buf[3] - CH_ZERO) * 10 + (line_buf[4] - CH_ZERO);
        sc = (line_buf[6] - CH_ZERO) * 10 + (line_buf[7] - CH_ZERO);
        fresh = 1'b1;
        r.event_res = EV_LOAD;
      end
      line_len  = 0;
      r.hours   = TIME_W'(hr);
      r.minutes = TIME_W'(mn);
      r.seconds = TIME_W'(sc);
    end else if (line_len < LINE_CHARS_DEF) begin
      line_buf[line_len] = ch;
      line_len++;
    end
    expected_times.push_back(r);
  endtask

  task automatic check_result();
    result_t want;
    result_t got;
    got.hours     = out_hours;
    got.minutes   = out_minutes;
    got.seconds   = out_seconds;
    got.event_res = event_t'(out_event_res);
    if (expected_times.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result %0d:%0d:%0d event %0d", got.hours, got.minutes,
                 got.seconds, got.event_res);
    end else begin
      want = expected_times.pop_front();
      results_seen++;
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected %0d:%0d:%0d event %0d, got %0d:%0d:%0d event %0d",
                   results_seen, want.hours, want.minutes, want.seconds, want.event_res,
                   got.hours, got.minutes, got.seconds, got.event_res);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      line_len = 0;
      hr = 0;
      mn = 0;
      sc = 0;
      fresh = 1'b0;
      expected_times.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) predict_clock_step(in_action, in_rx_byte);
    end
    fail_count <= mismatches;
    pending    <= expected_times.size();
    checked    <= results_seen;
  end

endmodule

// ===== tb/sv/serial_time_command_clock_core_tb.sv =====
// ----------------------------------------------------------------------------
// serial_time_command_clock_core_tb
// Drives serial bytes and one-second ticks into the time command clock:
// a short directed sequence, then random well-formed time and reset lines,
// tick bursts, broken lines, overlong lines and noise, with bursty input and
// a varying output stall. The checker beside the block scores every result.
// ----------------------------------------------------------------------------
module serial_time_command_clock_core_tb;
  import stcc_pkg::*;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int RANDOM_ITEMS = 650;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_action = 1'b0;
  logic [7:0]          in_rx_byte = 8'h00;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [TIME_W-1:0]   out_hours;
  logic [TIME_W-1:0]   out_minutes;
  logic [TIME_W-1:0]   out_seconds;
  logic [1:0]          out_event_res;

  int          fail_count;
  int          pending;
  int          checked;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          ticks_sent = 0;
  int          time_lines = 0;
  int          reset_lines = 0;
  int          other_lines = 0;
  int          burst_left = 0;
  int          stall_pct = 0;
  int          stall_left = 0;
  byte unsigned line_chars [$];

  serial_time_command_clock_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_hours    (out_hours),
    .out_minutes  (out_minutes),
    .out_seconds  (out_seconds),
    .out_event_res(out_event_res)
  );

  stcc_clock_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_hours    (out_hours),
    .out_minutes  (out_minutes),
    .out_seconds  (out_seconds),
    .out_event_res(out_event_res),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stall: stretches of fixed stall probability, 0% to 90%
  always @(posedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 30;
        2:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
      stall_left = $urandom_range(20, 300);
    end else begin
      stall_left--;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // one transfer; a gap may open before it when the current burst is used up
  task automatic put_item(input logic act, input logic [7:0] ch);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_action  <= act;
    in_rx_byte <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (act) ticks_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic add_text(input string t);
    for (int i = 0; i < t.len(); i++) line_chars.push_back(t[i]);
  endtask

  // the clear-time command text
  task automatic add_cmd_text();
    for (int i = 0; i < RESET_LEN; i++) line_chars.push_back(reset_char(4'(i)));
  endtask

  function automatic byte unsigned plain_char();
    byte unsigned c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_NEWLINE);
    return c;
  endfunction

  // sends the gathered bytes, optionally with ticks mixed in mid-line
  task automatic send_chars(input bit mix_ticks);
    foreach (line_chars[i]) begin
      if (mix_ticks && $urandom_range(0, 99) < 4) put_item(1'b1, 8'($urandom_range(0, 255)));
      put_item(1'b0, line_chars[i]);
    end
    line_chars.delete();
  endtask

  task automatic add_time_text();
    int h, m, s;
    case ($urandom_range(0, 3))
      0:       h = 23;
      1:       h = 99;
      default: h = $urandom_range(0, 99);
    endcase
    case ($urandom_range(0, 3))
      0:       m = 59;
      1:       m = 99;
      default: m = $urandom_range(0, 99);
    endcase
    case ($urandom_range(0, 3))
      0:       s = $urandom_range(50, 59);
      1:       s = $urandom_range(90, 99);
      default: s = $urandom_range(0, 99);
    endcase
    add_text($sformatf("%02d:%02d:%02d", h, m, s));
  endtask

  initial begin
    int kind, idx, pos, len, target, next_hold;
    byte unsigned c;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: tick from reset, load at the day boundary, fresh tick,
    // full wrap, reset command
    put_item(1'b1, 8'hFF);
    add_text("23:59:59");
    line_chars.push_back(CH_NEWLINE);
    send_chars(1'b0);
    put_item(1'b1, 8'h5A);
    put_item(1'b1, 8'hFF);
    put_item(1'b1, 8'h00);
    add_cmd_text();
    line_chars.push_back(CH_NEWLINE);
    send_chars(1'b0);
    time_lines++;
    reset_lines++;
    wait_drained();

    target = items_sent + RANDOM_ITEMS;
    next_hold = items_sent + 200;
    while (items_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        add_time_text();
        line_chars.push_back(CH_NEWLINE);
        send_chars(1'b1);
        time_lines++;
        if ($urandom_range(0, 99) < 70)
          repeat ($urandom_range(1, 12)) put_item(1'b1, 8'($urandom_range(0, 255)));
      end else if (kind < 40) begin
        add_cmd_text();
        if ($urandom_range(0, 99) < 25) begin
          case ($urandom_range(0, 2))
            0:       void'(line_chars.pop_back());
            1:       line_chars.push_back(plain_char());
            default: line_chars[$urandom_range(0, RESET_LEN - 1)] = plain_char();
          endcase
        end
        line_chars.push_back(CH_NEWLINE);
        send_chars(1'b1);
        reset_lines++;
      end else if (kind < 50) begin
        // time line with a non-digit in one digit position
        add_time_text();
        idx = $urandom_range(0, 5);
        pos = idx + idx / 2;
        do c = plain_char(); while (c >= CH_ZERO && c <= CH_NINE);
        line_chars[pos] = c;
        line_chars.push_back(CH_NEWLINE);
        send_chars(1'b1);
        other_lines++;
      end else if (kind < 70) begin
        repeat ($urandom_range(1, 25)) put_item(1'b1, 8'($urandom_range(0, 255)));
      end else if (kind < 82) begin
        repeat ($urandom_range(0, 20)) line_chars.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 70) line_chars.push_back(CH_NEWLINE);
        send_chars(1'b0);
        other_lines++;
      end else if (kind < 90) begin
        // overlong line, past the store capacity
        if ($urandom_range(0, 1)) add_cmd_text();
        len = $urandom_range(LINE_CHARS_DEF + 1, LINE_CHARS_DEF + 9);
        while (line_chars.size() < len) line_chars.push_back(plain_char());
        line_chars.push_back(CH_NEWLINE);
        send_chars(1'b1);
        other_lines++;
      end else begin
        // valid time text followed by extra characters
        add_time_text();
        repeat ($urandom_range(1, 7)) line_chars.push_back(plain_char());
        line_chars.push_back(CH_NEWLINE);
        send_chars(1'b0);
        other_lines++;
      end
      if (items_sent >= next_hold) begin
        wait_drained();
        next_hold = items_sent + 200;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Covered %0d transfers (%0d ticks); %0d results compared", items_sent,
             ticks_sent, checked);
    $display("Lines: %0d time, %0d reset, %0d malformed, overlong or noise", time_lines,
             reset_lines, other_lines);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
